// ===== rtl/assert_macros.svh =====
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is high
`define MKRE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mkre check failed");

// next-cycle implication, off while reset is high
`define MKRE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mkre check failed");

// what must hold in the cycle after reset
`define MKRE_ASSERT_AFTER_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("mkre check failed");

`endif

// ===== rtl/mkre_pkg.sv =====
// shared types, constants and register codes of the mouse key report engine
package mkre_pkg;

   localparam int TICK_WIDTH_DEFAULT = 32;

   localparam int MS_W        = 32;
   localparam int TIME_W      = 16;
   localparam int STEP_W      = 7;
   localparam int AXIS_W      = 8;
   localparam int BUTTON_W    = 5;
   localparam int SPEED_W     = 3;
   localparam int KEY_W       = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int DIV_NUM_W   = 32;
   localparam int DIV_DEN_W   = 16;
   localparam int MUL_B_W     = 16;

   localparam int BUTTON_LSB = 8;
   localparam int SPEED_LSB  = 13;

   localparam int TICK_RATE_HZ  = 61;
   localparam int REPORT_GAP_MS = 30;

   localparam logic [MUL_B_W-1:0]   MS_PER_SECOND = MUL_B_W'(1000);
   localparam logic [DIV_DEN_W-1:0] TICK_HZ       = DIV_DEN_W'(TICK_RATE_HZ);
   // scaled ms below this means less than the report gap
   localparam logic [MS_W-1:0] GAP_PRODUCT_LIMIT = MS_W'(REPORT_GAP_MS * TICK_RATE_HZ);

   localparam logic REQ_ACTIVATE = 1'b0;
   localparam logic REQ_REPORT   = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_POINTER_DELAY = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_POINTER_RAMP  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_POINTER_MAX   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_POINTER_MIN   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_WHEEL_DELAY   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_WHEEL_RAMP    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_WHEEL_MAX     = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_WHEEL_MIN     = 3'd7;

   typedef struct packed {
      logic [TIME_W-1:0] pointer_delay_ms;
      logic [TIME_W-1:0] pointer_ramp_ms;
      logic [STEP_W-1:0] pointer_max_step;
      logic [STEP_W-1:0] pointer_min_step;
      logic [TIME_W-1:0] wheel_delay_ms;
      logic [TIME_W-1:0] wheel_ramp_ms;
      logic [STEP_W-1:0] wheel_max_step;
      logic [STEP_W-1:0] wheel_min_step;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      pointer_delay_ms: TIME_W'(200),
      pointer_ramp_ms:  TIME_W'(1200),
      pointer_max_step: STEP_W'(35),
      pointer_min_step: STEP_W'(3),
      wheel_delay_ms:   TIME_W'(500),
      wheel_ramp_ms:    TIME_W'(2000),
      wheel_max_step:   STEP_W'(9),
      wheel_min_step:   STEP_W'(1)
   };

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] dividend;
      logic [DIV_DEN_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic start;
      logic take;
   } core_ctrl_type;

   typedef struct packed {
      logic idle;
      logic result_valid;
   } core_status_type;

   typedef struct packed {
      logic                     report_valid;
      logic signed [AXIS_W-1:0] move_x;
      logic signed [AXIS_W-1:0] move_y;
      logic signed [AXIS_W-1:0] wheel_v;
      logic signed [AXIS_W-1:0] wheel_h;
      logic [BUTTON_W-1:0]      buttons;
   } result_type;

endpackage

// ===== rtl/mkre_csr.sv =====
// configuration register file of the mouse key report engine
module mkre_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mkre_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mkre_pkg::CSR_DATA_W-1:0]   csr_data,
   output mkre_pkg::cfg_type                 cfg
);
   import mkre_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_POINTER_DELAY: cfg_in.pointer_delay_ms = csr_data[TIME_W-1:0];
            REG_POINTER_RAMP:  cfg_in.pointer_ramp_ms  = csr_data[TIME_W-1:0];
            REG_POINTER_MAX:   cfg_in.pointer_max_step = csr_data[STEP_W-1:0];
            REG_POINTER_MIN:   cfg_in.pointer_min_step = csr_data[STEP_W-1:0];
            REG_WHEEL_DELAY:   cfg_in.wheel_delay_ms   = csr_data[TIME_W-1:0];
            REG_WHEEL_RAMP:    cfg_in.wheel_ramp_ms    = csr_data[TIME_W-1:0];
            REG_WHEEL_MAX:     cfg_in.wheel_max_step   = csr_data[STEP_W-1:0];
            REG_WHEEL_MIN:     cfg_in.wheel_min_step   = csr_data[STEP_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/mkre_divider.sv =====
// shared restoring divider, two quotient bits a cycle
module mkre_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  mkre_pkg::div_req_type div_req,
   output mkre_pkg::div_rsp_type div_rsp
);
   import mkre_pkg::*;

   localparam int STEPS = DIV_NUM_W / 2;
   localparam int CNT_W = $clog2(STEPS);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_DEN_W:0]   first, second;

   function automatic logic [DIV_DEN_W:0] div_step(input logic [DIV_DEN_W-1:0] rem,
                                                   input logic din,
                                                   input logic [DIV_DEN_W-1:0] den);
      logic [DIV_DEN_W:0] t;
      logic [DIV_DEN_W:0] d;
      logic [DIV_DEN_W:0] diff;
      t    = {rem, din};
      d    = {1'b0, den};
      diff = t - d;
      if (t >= d) begin
         return {1'b1, diff[DIV_DEN_W-1:0]};
      end
      return {1'b0, t[DIV_DEN_W-1:0]};
   endfunction

   assign first  = div_step(rem_ff, num_ff[DIV_NUM_W-1], den_ff);
   assign second = div_step(first[DIV_DEN_W-1:0], num_ff[DIV_NUM_W-2], den_ff);

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = num_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS - 1);
         num_in  = div_req.dividend;
         rem_in  = '0;
         den_in  = div_req.divisor;
      end else if (busy_ff) begin
         num_in = {num_ff[DIV_NUM_W-3:0], first[DIV_DEN_W], second[DIV_DEN_W]};
         rem_in = second[DIV_DEN_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

endmodule

// ===== rtl/mkre_core.sv =====
// sequencer, key state and step arithmetic of the mouse key report engine
module mkre_core #(
   parameter int TICK_WIDTH = mkre_pkg::TICK_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mkre_pkg::core_ctrl_type       ctrl,
   output mkre_pkg::core_status_type     status,
   input  logic                          req_type,
   input  logic [mkre_pkg::KEY_W-1:0]    key_mask,
   input  logic [TICK_WIDTH-1:0]         tick_count,
   input  mkre_pkg::cfg_type             cfg,
   output mkre_pkg::result_type          result,
   output mkre_pkg::div_req_type         div_req,
   input  mkre_pkg::div_rsp_type         div_rsp
);
   import mkre_pkg::*;

   localparam int EXT_W = (TICK_WIDTH > MS_W) ? TICK_WIDTH : MS_W;
   localparam int RAW_W = STEP_W + 3;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_TIME      = 4'd1;
   localparam logic [3:0] ST_MS_DIV    = 4'd2;
   localparam logic [3:0] ST_MS_WAIT   = 4'd3;
   localparam logic [3:0] ST_GROUP     = 4'd4;
   localparam logic [3:0] ST_RAMP_DIV  = 4'd5;
   localparam logic [3:0] ST_STEP_WAIT = 4'd6;
   localparam logic [3:0] ST_CLAMP     = 4'd7;
   localparam logic [3:0] ST_APPLY     = 4'd8;
   localparam logic [3:0] ST_REPORT    = 4'd9;
   localparam logic [3:0] ST_OUT       = 4'd10;

   localparam logic GRP_POINTER = 1'b0;
   localparam logic GRP_WHEEL   = 1'b1;

   logic [3:0]               state_ff, state_in;
   logic                     type_ff, type_in;
   logic [KEY_W-1:0]         mask_ff, mask_in;
   logic [TICK_WIDTH-1:0]    now_ff, now_in;
   logic                     pressed_ff, pressed_in;
   logic [TICK_WIDTH-1:0]    start_ff, start_in;
   logic [TICK_WIDTH-1:0]    last_ff, last_in;
   logic [MS_W-1:0]          elapsed_ff, elapsed_in;
   logic signed [AXIS_W-1:0] axis_x_ff, axis_x_in;
   logic signed [AXIS_W-1:0] axis_y_ff, axis_y_in;
   logic signed [AXIS_W-1:0] axis_v_ff, axis_v_in;
   logic signed [AXIS_W-1:0] axis_h_ff, axis_h_in;
   logic [BUTTON_W-1:0]      button_ff, button_in;
   logic [SPEED_W-1:0]       speed_ff, speed_in;
   logic                     grp_ff, grp_in;
   logic [STEP_W-1:0]        base_ff, base_in;
   logic                     neg_ff, neg_in;
   logic signed [RAW_W-1:0]  raw_ff, raw_in;
   logic [STEP_W-1:0]        step_p_ff, step_p_in;
   logic [STEP_W-1:0]        step_w_ff, step_w_in;
   logic [MS_W-1:0]          prod_ff, prod_in;
   result_type               result_ff, result_in;

   logic [MS_W-1:0]           mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic [MS_W+MUL_B_W-1:0]   mul_full;
   logic [TICK_WIDTH-1:0]     base_tick;
   logic [TICK_WIDTH-1:0]     diff_tick;
   logic [EXT_W-1:0]          diff_ext;
   logic [STEP_W-1:0]         grp_min, grp_max;
   logic [TIME_W-1:0]         grp_delay, grp_ramp;
   logic [3:0]                grp_keys;
   logic [STEP_W-1:0]         grp_mag;
   logic [MS_W-1:0]           held_past_delay;
   logic [MS_W-1:0]           delay_ext, ramp_ext;
   logic signed [RAW_W-1:0]   quo_signed;
   logic [STEP_W-1:0]         clamped;
   logic                      axes_zero;

   function automatic logic signed [AXIS_W-1:0] key_apply(input logic signed [AXIS_W-1:0] a,
                                                          input logic [STEP_W-1:0] step,
                                                          input logic on,
                                                          input logic is_neg);
      logic signed [AXIS_W-1:0] s;
      logic signed [AXIS_W-1:0] r;
      s = $signed({1'b0, step});
      r = a;
      if (on) begin
         r = is_neg ? -s : s;
      end else if (is_neg ? (a < 0) : (a > 0)) begin
         r = '0;
      end
      return r;
   endfunction

   function automatic logic signed [AXIS_W-1:0] three_quarters(input logic signed [AXIS_W-1:0] v);
      logic signed [AXIS_W+1:0] w;
      logic signed [AXIS_W+1:0] t;
      logic signed [AXIS_W+1:0] q;
      w = $signed({{2{v[AXIS_W-1]}}, v});
      t = (w <<< 1) + w;
      q = t >>> 2;
      return q[AXIS_W-1:0];
   endfunction

   function automatic logic [STEP_W-1:0] clamp_step(input logic signed [RAW_W-1:0] raw,
                                                    input logic [STEP_W-1:0] mx);
      logic signed [RAW_W-1:0] u;
      logic signed [RAW_W-1:0] mxs;
      mxs = $signed({{(RAW_W-STEP_W){1'b0}}, mx});
      u   = raw;
      if (u > mxs) begin
         u = mxs;
      end
      if (u <= 0) begin
         u = $signed(RAW_W'(1));
      end
      return u[STEP_W-1:0];
   endfunction

   // per-group settings
   always_comb begin
      if (grp_ff == GRP_WHEEL) begin
         grp_min   = cfg.wheel_min_step;
         grp_max   = cfg.wheel_max_step;
         grp_delay = cfg.wheel_delay_ms;
         grp_ramp  = cfg.wheel_ramp_ms;
         grp_keys  = mask_ff[7:4];
      end else begin
         grp_min   = cfg.pointer_min_step;
         grp_max   = cfg.pointer_max_step;
         grp_delay = cfg.pointer_delay_ms;
         grp_ramp  = cfg.pointer_ramp_ms;
         grp_keys  = mask_ff[3:0];
      end
   end

   assign grp_mag         = (grp_max >= grp_min) ? (grp_max - grp_min) : (grp_min - grp_max);
   assign delay_ext       = {{(MS_W-TIME_W){1'b0}}, grp_delay};
   assign ramp_ext        = {{(MS_W-TIME_W){1'b0}}, grp_ramp};
   assign held_past_delay = elapsed_ff - delay_ext;

   assign base_tick = (type_ff == REQ_REPORT) ? last_ff : (pressed_ff ? start_ff : now_ff);
   assign diff_tick = now_ff - base_tick;
   assign diff_ext  = EXT_W'(diff_tick);

   // shared multiplier: tick distance times 1000, or step span times ramp position
   always_comb begin
      if (state_ff == ST_GROUP) begin
         mul_a = {{(MS_W-STEP_W){1'b0}}, grp_mag};
         mul_b = held_past_delay[MUL_B_W-1:0];
      end else begin
         mul_a = diff_ext[MS_W-1:0];
         mul_b = MS_PER_SECOND;
      end
   end

   assign mul_full = mul_a * mul_b;
   assign prod_in  = mul_full[MS_W-1:0];

   assign quo_signed = $signed({{(RAW_W-STEP_W){1'b0}}, div_rsp.quotient[STEP_W-1:0]});
   assign clamped    = clamp_step(raw_ff, grp_max);
   assign axes_zero  = (axis_x_ff == 0) && (axis_y_ff == 0) && (axis_v_ff == 0)
                       && (axis_h_ff == 0);

   assign status.idle         = (state_ff == ST_IDLE);
   assign status.result_valid = (state_ff == ST_OUT);
   assign result              = result_ff;

   always_comb begin
      state_in   = state_ff;
      type_in    = type_ff;
      mask_in    = mask_ff;
      now_in     = now_ff;
      pressed_in = pressed_ff;
      start_in   = start_ff;
      last_in    = last_ff;
      elapsed_in = elapsed_ff;
      axis_x_in  = axis_x_ff;
      axis_y_in  = axis_y_ff;
      axis_v_in  = axis_v_ff;
      axis_h_in  = axis_h_ff;
      button_in  = button_ff;
      speed_in   = speed_ff;
      grp_in     = grp_ff;
      base_in    = base_ff;
      neg_in     = neg_ff;
      raw_in     = raw_ff;
      step_p_in  = step_p_ff;
      step_w_in  = step_w_ff;
      result_in  = result_ff;
      div_req    = '0;

      case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               type_in  = req_type;
               mask_in  = key_mask;
               now_in   = tick_count;
               state_in = ST_TIME;
            end
         end
         ST_TIME: begin
            if (type_ff == REQ_REPORT) begin
               state_in = ST_REPORT;
            end else if (mask_ff == '0) begin
               axis_x_in  = '0;
               axis_y_in  = '0;
               axis_v_in  = '0;
               axis_h_in  = '0;
               button_in  = '0;
               speed_in   = '0;
               start_in   = '0;
               pressed_in = 1'b0;
               result_in  = '0;
               state_in   = ST_OUT;
            end else begin
               if (!pressed_ff) begin
                  start_in   = now_ff;
                  pressed_in = 1'b1;
               end
               state_in = ST_MS_DIV;
            end
         end
         ST_MS_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff;
            div_req.divisor  = TICK_HZ;
            state_in         = ST_MS_WAIT;
         end
         ST_MS_WAIT: begin
            if (div_rsp.done) begin
               elapsed_in = div_rsp.quotient;
               grp_in     = GRP_POINTER;
               state_in   = ST_GROUP;
            end
         end
         ST_GROUP: begin
            if (grp_keys == '0) begin
               if (grp_ff == GRP_POINTER) begin
                  grp_in = GRP_WHEEL;
               end else begin
                  state_in = ST_APPLY;
               end
            end else if (speed_ff[0]) begin
               div_req.start    = 1'b1;
               div_req.dividend = {{(DIV_NUM_W-STEP_W){1'b0}}, grp_max};
               div_req.divisor  = {{(DIV_DEN_W-SPEED_W){1'b0}}, speed_ff};
               base_in          = '0;
               neg_in           = 1'b0;
               state_in         = ST_STEP_WAIT;
            end else if (elapsed_ff < delay_ext) begin
               raw_in   = $signed({{(RAW_W-STEP_W){1'b0}}, grp_min});
               state_in = ST_CLAMP;
            end else if (elapsed_ff >= ramp_ext) begin
               raw_in   = $signed({{(RAW_W-STEP_W){1'b0}}, grp_max});
               state_in = ST_CLAMP;
            end else begin
               base_in  = grp_min;
               neg_in   = (grp_min > grp_max);
               state_in = ST_RAMP_DIV;
            end
         end
         ST_RAMP_DIV: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff;
            div_req.divisor  = grp_ramp;
            state_in         = ST_STEP_WAIT;
         end
         ST_STEP_WAIT: begin
            if (div_rsp.done) begin
               raw_in   = $signed({{(RAW_W-STEP_W){1'b0}}, base_ff})
                          + (neg_ff ? -quo_signed : quo_signed);
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            if (grp_ff == GRP_POINTER) begin
               step_p_in = clamped;
               grp_in    = GRP_WHEEL;
               state_in  = ST_GROUP;
            end else begin
               step_w_in = clamped;
               state_in  = ST_APPLY;
            end
         end
         ST_APPLY: begin
            // the higher mask bit of an opposing pair wins
            axis_y_in = key_apply(key_apply(axis_y_ff, step_p_ff, mask_ff[0], 1'b1),
                                  step_p_ff, mask_ff[1], 1'b0);
            axis_x_in = key_apply(key_apply(axis_x_ff, step_p_ff, mask_ff[2], 1'b1),
                                  step_p_ff, mask_ff[3], 1'b0);
            axis_v_in = key_apply(key_apply(axis_v_ff, step_w_ff, mask_ff[4], 1'b0),
                                  step_w_ff, mask_ff[5], 1'b1);
            axis_h_in = key_apply(key_apply(axis_h_ff, step_w_ff, mask_ff[6], 1'b1),
                                  step_w_ff, mask_ff[7], 1'b0);
            button_in = mask_ff[BUTTON_LSB +: BUTTON_W];
            speed_in  = mask_ff[SPEED_LSB +: SPEED_W];
            result_in = '0;
            state_in  = ST_OUT;
         end
         ST_REPORT: begin
            if ((button_ff == '0) && (axes_zero || (prod_ff < GAP_PRODUCT_LIMIT))) begin
               result_in = '0;
            end else begin
               last_in                = now_ff;
               result_in.report_valid = 1'b1;
               result_in.move_x       = axis_x_ff;
               result_in.move_y       = axis_y_ff;
               if ((axis_x_ff != 0) && (axis_y_ff != 0)) begin
                  result_in.move_x = three_quarters(axis_x_ff);
                  result_in.move_y = three_quarters(axis_y_ff);
               end
               result_in.wheel_v = axis_v_ff;
               result_in.wheel_h = axis_h_ff;
               result_in.buttons = button_ff;
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (ctrl.take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pressed_ff <= 1'b0;
         start_ff   <= '0;
         last_ff    <= '0;
         elapsed_ff <= '0;
         axis_x_ff  <= '0;
         axis_y_ff  <= '0;
         axis_v_ff  <= '0;
         axis_h_ff  <= '0;
         button_ff  <= '0;
         speed_ff   <= '0;
         grp_ff     <= GRP_POINTER;
      end else begin
         state_ff   <= state_in;
         pressed_ff <= pressed_in;
         start_ff   <= start_in;
         last_ff    <= last_in;
         elapsed_ff <= elapsed_in;
         axis_x_ff  <= axis_x_in;
         axis_y_ff  <= axis_y_in;
         axis_v_ff  <= axis_v_in;
         axis_h_ff  <= axis_h_in;
         button_ff  <= button_in;
         speed_ff   <= speed_in;
         grp_ff     <= grp_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      mask_ff   <= mask_in;
      now_ff    <= now_in;
      base_ff   <= base_in;
      neg_ff    <= neg_in;
      raw_ff    <= raw_in;
      step_p_ff <= step_p_in;
      step_w_ff <= step_w_in;
      prod_ff   <= prod_in;
      result_ff <= result_in;
   end

endmodule

// ===== rtl/mouse_key_report_engine.sv =====
// top level of the mouse key report engine: handshakes, response register, units
//
// req channel: one word per request, either an activate carrying the 16-key mask or
// a report request; the tick count rides along with both. one rsp word comes back
// for every req word; report_valid low means nothing to send and all fields zero.
// csr channel: register index and data, always ready; the user must see that it is
// written only while idle, as no check in the block enforces this.
// req_ready is high only while the sequencer is idle, so one request is in flight.
// a report request and an activate with an empty mask need no division; the time of
// any other activate is set by the shared divider at two quotient bits a cycle:
// one division for the held time, and one more per pointer or wheel group whose
// step lies on the ramp or under the first speed key.
// with a ready receiver the sequencer goes back to idle as the word enters the rsp
// register, so a new request is taken only once the previous result has left it.
// a finished word waits in the rsp register, so a new request is taken while the
// receiver stalls; its own result then waits in the sequencer until the register
// frees. reset clears all key state, the response valid flag and the sequencer and
// loads the default settings.
module mouse_key_report_engine #(
   parameter int TICK_WIDTH = mkre_pkg::TICK_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_type,
   input  logic [mkre_pkg::KEY_W-1:0]             req_key_mask,
   input  logic [TICK_WIDTH-1:0]                  req_tick_count,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_report_valid,
   output logic signed [mkre_pkg::AXIS_W-1:0]     rsp_move_x,
   output logic signed [mkre_pkg::AXIS_W-1:0]     rsp_move_y,
   output logic signed [mkre_pkg::AXIS_W-1:0]     rsp_wheel_v,
   output logic signed [mkre_pkg::AXIS_W-1:0]     rsp_wheel_h,
   output logic [mkre_pkg::BUTTON_W-1:0]          rsp_buttons,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [mkre_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [mkre_pkg::CSR_DATA_W-1:0]        csr_data
);
   import mkre_pkg::*;

   cfg_type         cfg;
   core_ctrl_type   core_ctrl;
   core_status_type core_status;
   result_type      core_result;
   div_req_type     div_req;
   div_rsp_type     div_rsp;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_word_ff;

   assign req_ready      = core_status.idle;
   assign core_ctrl.start = req_valid && core_status.idle;
   assign core_ctrl.take  = core_status.result_valid && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (core_ctrl.take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_ctrl.take) begin
         rsp_word_ff <= core_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_report_valid = rsp_word_ff.report_valid;
   assign rsp_move_x       = rsp_word_ff.move_x;
   assign rsp_move_y       = rsp_word_ff.move_y;
   assign rsp_wheel_v      = rsp_word_ff.wheel_v;
   assign rsp_wheel_h      = rsp_word_ff.wheel_h;
   assign rsp_buttons      = rsp_word_ff.buttons;

   mkre_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mkre_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   mkre_core #(
      .TICK_WIDTH (TICK_WIDTH)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (core_ctrl),
      .status     (core_status),
      .req_type   (req_type),
      .key_mask   (req_key_mask),
      .tick_count (req_tick_count),
      .cfg        (cfg),
      .result     (core_result),
      .div_req    (div_req),
      .div_rsp    (div_rsp)
   );

endmodule

// ===== rtl/mkre_checker.sv =====
// port-level checks of the mouse key report engine and their binding
`include "assert_macros.svh"

module mkre_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_report_valid,
   input logic [7:0] rsp_move_x,
   input logic [7:0] rsp_move_y,
   input logic [7:0] rsp_wheel_v,
   input logic [7:0] rsp_wheel_h,
   input logic [4:0] rsp_buttons
);

   // a stalled word keeps its valid, report flag, x move and buttons
   `MKRE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_report_valid) && $stable(rsp_move_x) && $stable(rsp_buttons))

   // no report means an all-zero word
   `MKRE_ASSERT_IMPLY(a_empty_word, clock, reset, rsp_valid && !rsp_report_valid, rsp_move_x == 8'h00 && rsp_move_y == 8'h00 && rsp_wheel_v == 8'h00 && rsp_wheel_h == 8'h00 && rsp_buttons == 5'h00)

   // moves stay within plus or minus 127
   `MKRE_ASSERT_IMPLY(a_move_range, clock, reset, rsp_valid, rsp_move_x != 8'h80 && rsp_move_y != 8'h80 && rsp_wheel_v != 8'h80 && rsp_wheel_h != 8'h80)

   // one request in flight at a time
   `MKRE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // out of reset: idle and nothing pending
   `MKRE_ASSERT_AFTER_RESET(a_reset_idle, clock, reset, !rsp_valid && req_ready)

endmodule

bind mouse_key_report_engine mkre_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_report_valid (rsp_report_valid),
   .rsp_move_x       (rsp_move_x),
   .rsp_move_y       (rsp_move_y),
   .rsp_wheel_v      (rsp_wheel_v),
   .rsp_wheel_h      (rsp_wheel_h),
   .rsp_buttons      (rsp_buttons)
);
